// ===== hdl/plob_pkg.sv =====
// shared types, codes and defaults for the price level order book
package plob_pkg;

   localparam int ORDER_SLOTS_DEF  = 1024;
   localparam int PRICE_LEVELS_DEF = 1024;
   localparam int QTY_BITS_DEF     = 16;

   // occupancy bitmap group width for the best price search
   localparam int GRP_W = 32;

   localparam logic [1:0] ACT_ADD    = 2'd0;
   localparam logic [1:0] ACT_CANCEL = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LEVEL,
      ST_UPDATE,
      ST_SEARCH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic level;
      logic update;
      logic search;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rsp_busy;
   } status_type;

endpackage

// ===== hdl/plob_req_if.sv =====
// request channel of the order book
interface plob_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [9:0] order_id;
   logic       side;
   logic [9:0] price;
   logic [15:0] quantity;

   modport source (output valid, output action, output order_id, output side,
                   output price, output quantity, input ready);
   modport sink   (input valid, input action, input order_id, input side,
                   input price, input quantity, output ready);
endinterface

// ===== hdl/plob_rsp_if.sv =====
// response channel of the order book
interface plob_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic        bid_valid;
   logic [9:0]  best_bid;
   logic        ask_valid;
   logic [9:0]  best_ask;
   logic [26:0] level_total;

   modport source (output valid, output accepted, output bid_valid, output best_bid,
                   output ask_valid, output best_ask, output level_total, input ready);
   modport sink   (input valid, input accepted, input bid_valid, input best_bid,
                   input ask_valid, input best_ask, input level_total, output ready);
endinterface

// ===== hdl/plob_ctrl.sv =====
// sequencing state machine of the order book
module plob_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  plob_pkg::status_type  stat,
   output plob_pkg::cmd_type     cmd
);

   plob_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plob_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         plob_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = plob_pkg::ST_IDLE;
            end
         end
         plob_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = plob_pkg::ST_LEVEL;
            end
         end
         plob_pkg::ST_LEVEL: begin
            cmd.level = 1'b1;
            state_in  = plob_pkg::ST_UPDATE;
         end
         plob_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = plob_pkg::ST_SEARCH;
         end
         plob_pkg::ST_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = plob_pkg::ST_RESULT;
         end
         plob_pkg::ST_RESULT: begin
            if (!stat.rsp_busy) begin
               cmd.load = 1'b1;
               state_in = plob_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plob_pkg::ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== hdl/plob_datapath.sv =====
// order table, level sums, occupancy bitmaps and response register
module plob_datapath #(
   parameter int ORDER_SLOTS  = plob_pkg::ORDER_SLOTS_DEF,
   parameter int PRICE_LEVELS = plob_pkg::PRICE_LEVELS_DEF,
   parameter int QTY_BITS     = plob_pkg::QTY_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  plob_pkg::cmd_type    cmd,
   output plob_pkg::status_type stat,
   input  logic [1:0]           req_action,
   input  logic [9:0]           req_order_id,
   input  logic                 req_side,
   input  logic [9:0]           req_price,
   input  logic [15:0]          req_quantity,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic                 rsp_accepted,
   output logic                 rsp_bid_valid,
   output logic [9:0]           rsp_best_bid,
   output logic                 rsp_ask_valid,
   output logic [9:0]           rsp_best_ask,
   output logic [26:0]          rsp_level_total
);

   localparam int OID_W = $clog2(ORDER_SLOTS);
   localparam int LVL_W = $clog2(PRICE_LEVELS);
   localparam int SUM_W = QTY_BITS + OID_W;
   localparam int ORD_W = 2 + LVL_W + QTY_BITS;
   localparam int NGRP  = (PRICE_LEVELS + plob_pkg::GRP_W - 1) / plob_pkg::GRP_W;
   localparam int GIW   = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int BIT_W = $clog2(plob_pkg::GRP_W);
   localparam int CLR_N = (ORDER_SLOTS > PRICE_LEVELS) ? ORDER_SLOTS : PRICE_LEVELS;
   localparam int CLR_W = $clog2(CLR_N);

   // order entry layout: live, sell, tick, amount
   localparam int LIVE_B = ORD_W - 1;
   localparam int SELL_B = ORD_W - 2;

   logic [ORD_W-1:0] order_mem [ORDER_SLOTS];
   logic [SUM_W-1:0] buy_mem   [PRICE_LEVELS];
   logic [SUM_W-1:0] sell_mem  [PRICE_LEVELS];

   logic [plob_pkg::GRP_W-1:0] buy_map_ff  [NGRP];
   logic [plob_pkg::GRP_W-1:0] sell_map_ff [NGRP];

   logic [CLR_W-1:0]    clr_cnt_ff;
   logic [1:0]          act_ff;
   logic [9:0]          id_ff;
   logic                side_ff;
   logic [9:0]          price_ff;
   logic [QTY_BITS-1:0] qty_ff;
   logic [ORD_W-1:0]    order_q_ff;
   logic [SUM_W-1:0]    buy_q_ff, sell_q_ff;
   logic                ok_ff, ok_in;
   logic [LVL_W-1:0]    lvl_addr_ff, lvl_addr_in;
   logic                sel_sell_ff, sel_sell_in;
   logic [QTY_BITS-1:0] amt_ff, amt_in;
   logic                accepted_ff;
   logic [26:0]         total_ff;
   logic [GIW-1:0]      bid_grp_ff, ask_grp_ff, bid_grp_in, ask_grp_in;
   logic                bid_any_ff, ask_any_ff, bid_any_in, ask_any_in;
   logic                rsp_valid_ff;
   logic                rsp_acc_ff, rsp_bv_ff, rsp_av_ff;
   logic [9:0]          rsp_bid_ff, rsp_ask_ff;
   logic [26:0]         rsp_total_ff;

   logic                id_ok, price_ok, live_q;
   logic [SUM_W-1:0]    cur_sum, new_sum;
   logic [GIW-1:0]      upd_grp;
   logic [BIT_W-1:0]    upd_bit;
   logic [BIT_W-1:0]    bid_bit, ask_bit;
   logic [plob_pkg::GRP_W-1:0] bid_word, ask_word;

   assign id_ok    = 32'(id_ff) < ORDER_SLOTS;
   assign price_ok = 32'(price_ff) < PRICE_LEVELS;
   assign live_q   = order_q_ff[LIVE_B];

   assign stat.clear_last = (clr_cnt_ff == CLR_W'(CLR_N - 1));
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear && !stat.clear_last) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // request capture and order table
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff     <= req_action;
         id_ff      <= req_order_id;
         side_ff    <= req_side;
         price_ff   <= req_price;
         qty_ff     <= QTY_BITS'(req_quantity);
         order_q_ff <= order_mem[OID_W'(req_order_id)];
      end
      if (cmd.clear && (32'(clr_cnt_ff) < ORDER_SLOTS)) begin
         order_mem[OID_W'(clr_cnt_ff)] <= '0;
      end else if (cmd.update && ok_ff) begin
         order_mem[OID_W'(id_ff)] <= {(act_ff == plob_pkg::ACT_ADD), sel_sell_ff,
                                      lvl_addr_ff, amt_ff};
      end
   end

   // decide and pick the level address
   always_comb begin
      ok_in       = 1'b0;
      lvl_addr_in = LVL_W'(price_ff);
      sel_sell_in = side_ff;
      amt_in      = qty_ff;
      unique case (act_ff)
         plob_pkg::ACT_ADD: begin
            ok_in = id_ok && price_ok && (qty_ff != '0) && !live_q;
         end
         plob_pkg::ACT_CANCEL: begin
            ok_in       = id_ok && live_q;
            lvl_addr_in = order_q_ff[SELL_B-1 -: LVL_W];
            sel_sell_in = order_q_ff[SELL_B];
            amt_in      = order_q_ff[QTY_BITS-1:0];
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.level) begin
         ok_ff       <= ok_in;
         lvl_addr_ff <= lvl_addr_in;
         sel_sell_ff <= sel_sell_in;
         amt_ff      <= amt_in;
         buy_q_ff    <= buy_mem[lvl_addr_in];
         sell_q_ff   <= sell_mem[lvl_addr_in];
      end
   end

   // level sum update
   assign cur_sum = sel_sell_ff ? sell_q_ff : buy_q_ff;
   assign new_sum = (act_ff == plob_pkg::ACT_ADD) ? cur_sum + SUM_W'(amt_ff)
                                                  : cur_sum - SUM_W'(amt_ff);
   assign upd_grp = GIW'(lvl_addr_ff >> BIT_W);
   assign upd_bit = BIT_W'(lvl_addr_ff);

   always_ff @(posedge clock) begin
      if (cmd.clear && (32'(clr_cnt_ff) < PRICE_LEVELS)) begin
         buy_mem[LVL_W'(clr_cnt_ff)]  <= '0;
         sell_mem[LVL_W'(clr_cnt_ff)] <= '0;
      end else if (cmd.update && ok_ff) begin
         if (sel_sell_ff) begin
            sell_mem[lvl_addr_ff] <= new_sum;
         end else begin
            buy_mem[lvl_addr_ff] <= new_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         accepted_ff <= (act_ff == plob_pkg::ACT_QUERY) ? 1'b1 : ok_ff;
         if ((act_ff == plob_pkg::ACT_QUERY) && price_ok) begin
            total_ff <= 27'({1'b0, buy_q_ff} + {1'b0, sell_q_ff});
         end else begin
            total_ff <= '0;
         end
      end
   end

   // occupancy bitmaps
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < NGRP; g++) begin
            buy_map_ff[g]  <= '0;
            sell_map_ff[g] <= '0;
         end
      end else if (cmd.update && ok_ff) begin
         if (sel_sell_ff) begin
            sell_map_ff[upd_grp][upd_bit] <= (new_sum != '0);
         end else begin
            buy_map_ff[upd_grp][upd_bit] <= (new_sum != '0);
         end
      end
   end

   // first search step: pick the group
   always_comb begin
      bid_grp_in = '0;
      ask_grp_in = '0;
      bid_any_in = 1'b0;
      ask_any_in = 1'b0;
      for (int g = 0; g < NGRP; g++) begin
         if (|buy_map_ff[g]) begin
            bid_grp_in = GIW'(g);
            bid_any_in = 1'b1;
         end
      end
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (|sell_map_ff[g]) begin
            ask_grp_in = GIW'(g);
            ask_any_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search) begin
         bid_grp_ff <= bid_grp_in;
         ask_grp_ff <= ask_grp_in;
         bid_any_ff <= bid_any_in;
         ask_any_ff <= ask_any_in;
      end
   end

   // second search step: pick the bit inside the group
   assign bid_word = buy_map_ff[bid_grp_ff];
   assign ask_word = sell_map_ff[ask_grp_ff];

   always_comb begin
      bid_bit = '0;
      ask_bit = '0;
      for (int b = 0; b < plob_pkg::GRP_W; b++) begin
         if (bid_word[b]) begin
            bid_bit = BIT_W'(b);
         end
      end
      for (int b = plob_pkg::GRP_W - 1; b >= 0; b--) begin
         if (ask_word[b]) begin
            ask_bit = BIT_W'(b);
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_acc_ff   <= accepted_ff;
         rsp_total_ff <= total_ff;
         rsp_bv_ff    <= bid_any_ff;
         rsp_av_ff    <= ask_any_ff;
         rsp_bid_ff   <= bid_any_ff ? 10'({bid_grp_ff, bid_bit}) : '0;
         rsp_ask_ff   <= ask_any_ff ? 10'({ask_grp_ff, ask_bit}) : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_bid_valid   = rsp_bv_ff;
   assign rsp_best_bid    = rsp_bid_ff;
   assign rsp_ask_valid   = rsp_av_ff;
   assign rsp_best_ask    = rsp_ask_ff;
   assign rsp_level_total = rsp_total_ff;

endmodule

// ===== hdl/price_level_order_book_top.sv =====
// top level of the price level order book
// a request passes ST_LEVEL, ST_UPDATE, ST_SEARCH and ST_RESULT in turn; ST_RESULT
//   holds while the response side is busy; the next request is taken only after the
//   response is loaded, as the order table read, level read, level write and
//   two-step best price search are done in turn
// reset: synchronous; a clearing sweep follows, during which no request is taken
module price_level_order_book_top #(
   parameter int ORDER_SLOTS  = plob_pkg::ORDER_SLOTS_DEF,
   parameter int PRICE_LEVELS = plob_pkg::PRICE_LEVELS_DEF,
   parameter int QTY_BITS     = plob_pkg::QTY_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   plob_req_if.sink   req_if,
   plob_rsp_if.source rsp_if
);

   // command and status between sequencer and datapath
   plob_pkg::cmd_type    cmd;
   plob_pkg::status_type stat;
   logic                 req_ready;

   assign req_if.ready = req_ready;

   // sequencer: clearing sweep, then one request at a time through the stages
   plob_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: order table, level sums, occupancy bitmaps, response register
   plob_datapath #(
      .ORDER_SLOTS  (ORDER_SLOTS),
      .PRICE_LEVELS (PRICE_LEVELS),
      .QTY_BITS     (QTY_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_action      (req_if.action),
      .req_order_id    (req_if.order_id),
      .req_side        (req_if.side),
      .req_price       (req_if.price),
      .req_quantity    (req_if.quantity),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_accepted    (rsp_if.accepted),
      .rsp_bid_valid   (rsp_if.bid_valid),
      .rsp_best_bid    (rsp_if.best_bid),
      .rsp_ask_valid   (rsp_if.ask_valid),
      .rsp_best_ask    (rsp_if.best_ask),
      .rsp_level_total (rsp_if.level_total)
   );

   // only one request in flight
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request taken while another is in flight");

   // a new response never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_if.valid || rsp_if.ready))
      else $error("response register overwritten");

   // no request during the clearing sweep
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_if.ready)
      else $error("request taken during clearing sweep");

endmodule
